/* sv/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// Pressure and temperature compensation package
// Widths, register indexes, output limits and wrapping multiply helpers.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned AdcW    = 20;
  localparam int unsigned CalW    = 48;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 15;
  localparam int unsigned PressW  = 25;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivW    = 64;
  localparam int unsigned DsrW    = 31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_CAL    = 2'd0,
    REG_PRESS_CAL_A = 2'd1,
    REG_PRESS_CAL_B = 2'd2,
    REG_PRESS_CAL_C = 2'd3
  } cfg_reg_e;

  localparam logic signed [TempW-1:0] TempMin  = -15'sd4000;
  localparam logic signed [TempW-1:0] TempMax  = 15'sd8500;
  localparam logic [PressW-1:0]       PressMax = '1;

  // Low 64 bits of x times an unsigned 16-bit word.
  function automatic logic [63:0] mul_u16(input logic [63:0] x, input logic [WordW-1:0] y);
    logic [79:0] prod;
    prod = 80'(x) * 80'(y);
    return prod[63:0];
  endfunction

  // Low 64 bits of x times a signed 16-bit word.
  function automatic logic [63:0] mul_s16(input logic [63:0] x, input logic [WordW-1:0] y);
    logic [79:0] prod;
    prod = 80'(x) * 80'(y);
    return prod[63:0] - (y[WordW-1] ? {x[47:0], 16'h0000} : 64'h0);
  endfunction

endpackage

/* sv/ptc_in_if.sv */
// ----------------------------------------------------------------------------
// Raw reading channel
// Carries one temperature and one pressure conversion per beat.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  import ptc_pkg::*;

  logic            valid;
  logic            ready;
  logic [AdcW-1:0] adc_temperature;
  logic [AdcW-1:0] adc_pressure;

  modport source (output valid, output adc_temperature, output adc_pressure, input ready);
  modport sink   (input valid, input adc_temperature, input adc_pressure, output ready);

endinterface

/* sv/ptc_out_if.sv */
// ----------------------------------------------------------------------------
// Compensated result channel
// Carries temperature, pressure and the divide error flag per beat.
// ----------------------------------------------------------------------------
interface ptc_out_if;
  import ptc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature_centi;
  logic [PressW-1:0]       pressure_q24_8;
  logic                    divide_error;

  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output divide_error, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                  input divide_error, output ready);

endinterface

/* sv/pressure_temperature_compensation.sv */
// ----------------------------------------------------------------------------
// Pressure and temperature compensation
// Throughput: one beat per cycle while the output is taken; the 64-stage restoring divider sets depth.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the calibration registers and all valid bits.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ptc_pkg::CalW-1:0]      cfg_data_i,
  ptc_in_if.sink                        in_if,
  ptc_out_if.source                     out_if
);
  import ptc_pkg::*;

  localparam int unsigned NStage = 8 + DivW + 6;

  logic [CalW-1:0] cal_t_q, cal_a_q, cal_b_q, cal_c_q;
  logic [WordW-1:0] t1, p1;
  logic signed [WordW-1:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q <= '0;
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TEMP_CAL:    cal_t_q <= cfg_data_i;
        REG_PRESS_CAL_A: cal_a_q <= cfg_data_i;
        REG_PRESS_CAL_B: cal_b_q <= cfg_data_i;
        REG_PRESS_CAL_C: cal_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign t1 = cal_t_q[15:0];
  assign t2 = cal_t_q[31:16];
  assign t3 = cal_t_q[47:32];
  assign p1 = cal_a_q[15:0];
  assign p2 = cal_a_q[31:16];
  assign p3 = cal_a_q[47:32];
  assign p4 = cal_b_q[15:0];
  assign p5 = cal_b_q[31:16];
  assign p6 = cal_b_q[47:32];
  assign p7 = cal_c_q[15:0];
  assign p8 = cal_c_q[31:16];
  assign p9 = cal_c_q[47:32];

  logic              adv;
  logic [NStage-1:0] v_q;

  assign adv         = !v_q[NStage-1] || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = v_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStage-2:0], in_if.valid};
    end
  end

  // Temperature path.
  logic signed [17:0] s0_ta;
  logic signed [16:0] s0_td;
  logic signed [33:0] s0_sq;
  logic signed [33:0] s1_at_q;
  logic [32:0]        s1_dd_q;
  logic [AdcW-1:0]    s1_adcp_q;

  assign s0_ta = signed'({1'b0, in_if.adc_temperature[AdcW-1:3]}) - signed'({1'b0, t1, 1'b0});
  assign s0_td = signed'({1'b0, in_if.adc_temperature[AdcW-1:4]}) - signed'({1'b0, t1});
  assign s0_sq = 34'(s0_td) * 34'(s0_td);

  logic signed [22:0] s2_a_q;
  logic signed [37:0] s2_bt_q;
  logic [AdcW-1:0]    s2_adcp_q;

  logic signed [24:0] s3_tf_q;
  logic [AdcW-1:0]    s3_adcp_q;

  logic signed [25:0] s3_pa;
  logic signed [27:0] s3_t5;
  logic signed [19:0] s3_tc;
  logic signed [TempW-1:0] s3_temp;
  logic signed [51:0] s3_aa;

  assign s3_pa = 26'(s3_tf_q) - 26'sd128000;
  assign s3_t5 = 28'(s3_tf_q) * 28'sd5 + 28'sd128;
  assign s3_tc = s3_t5[27:8];
  assign s3_aa = 52'(s3_pa) * 52'(s3_pa);

  always_comb begin
    if (s3_tc < 20'(TempMin)) begin
      s3_temp = TempMin;
    end else if (s3_tc > 20'(TempMax)) begin
      s3_temp = TempMax;
    end else begin
      s3_temp = s3_tc[TempW-1:0];
    end
  end

  logic [51:0]             s4_aa_q;
  logic signed [41:0]      s4_ap5_q, s4_ap2_q;
  logic signed [TempW-1:0] s4_temp_q;
  logic [AdcW-1:0]         s4_adcp_q;

  logic [63:0]             s5_m6_q, s5_m3_q;
  logic signed [41:0]      s5_ap5_q, s5_ap2_q;
  logic signed [TempW-1:0] s5_temp_q;
  logic [AdcW-1:0]         s5_adcp_q;

  logic [63:0]             s6_b_q, s6_a2_q;
  logic signed [TempW-1:0] s6_temp_q;
  logic [AdcW-1:0]         s6_adcp_q;

  logic [20:0]             s6_pp;
  assign s6_pp = 21'h10_0000 - 21'(s6_adcp_q);

  logic [63:0]             s7_m1_q, s7_num_q;
  logic signed [TempW-1:0] s7_temp_q;

  logic signed [DsrW-1:0]  s7_dv;
  assign s7_dv = s7_m1_q[63:33];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_at_q   <= 34'(s0_ta) * 34'(t2);
      s1_dd_q   <= s0_sq[32:0];
      s1_adcp_q <= in_if.adc_pressure;

      s2_a_q    <= s1_at_q[33:11];
      s2_bt_q   <= 38'(signed'({1'b0, s1_dd_q[32:12]})) * 38'(t3);
      s2_adcp_q <= s1_adcp_q;

      s3_tf_q   <= 25'(s2_a_q) + 25'(signed'(s2_bt_q[37:14]));
      s3_adcp_q <= s2_adcp_q;

      s4_aa_q   <= s3_aa;
      s4_ap5_q  <= 42'(s3_pa) * 42'(p5);
      s4_ap2_q  <= 42'(s3_pa) * 42'(p2);
      s4_temp_q <= s3_temp;
      s4_adcp_q <= s3_adcp_q;

      s5_m6_q   <= mul_s16({12'h000, s4_aa_q}, p6);
      s5_m3_q   <= mul_s16({12'h000, s4_aa_q}, p3);
      s5_ap5_q  <= s4_ap5_q;
      s5_ap2_q  <= s4_ap2_q;
      s5_temp_q <= s4_temp_q;
      s5_adcp_q <= s4_adcp_q;

      s6_b_q    <= s5_m6_q + (64'(s5_ap5_q) << 17) + (64'(p4) << 35);
      s6_a2_q   <= {{8{s5_m3_q[63]}}, s5_m3_q[63:8]} + (64'(s5_ap2_q) << 12);
      s6_temp_q <= s5_temp_q;
      s6_adcp_q <= s5_adcp_q;

      s7_m1_q   <= mul_u16(64'h0000_8000_0000_0000 + s6_a2_q, p1);
      s7_num_q  <= 64'(((64'(s6_pp) << 31) - s6_b_q) * 64'd3125);
      s7_temp_q <= s6_temp_q;
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [DsrW-1:0]         dv_rem_q  [DivW+1];
  logic [DivW-1:0]         dv_dvd_q  [DivW+1];
  logic [DsrW-1:0]         dv_dsr_q  [DivW+1];
  logic                    dv_neg_q  [DivW+1];
  logic                    dv_err_q  [DivW+1];
  logic signed [TempW-1:0] dv_temp_q [DivW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0]  <= '0;
      dv_dvd_q[0]  <= s7_num_q[63] ? 64'(-s7_num_q) : s7_num_q;
      dv_dsr_q[0]  <= s7_dv[DsrW-1] ? DsrW'(-s7_dv) : DsrW'(s7_dv);
      dv_neg_q[0]  <= s7_num_q[63] ^ s7_dv[DsrW-1];
      dv_err_q[0]  <= (s7_dv == '0);
      dv_temp_q[0] <= s7_temp_q;
    end
  end

  for (genvar k = 0; k < DivW; k++) begin : g_div
    logic [DsrW:0] trial;
    logic          take;

    assign trial = {dv_rem_q[k], dv_dvd_q[k][DivW-1]};
    assign take  = trial >= {1'b0, dv_dsr_q[k]};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[k+1]  <= take ? DsrW'(trial - {1'b0, dv_dsr_q[k]}) : trial[DsrW-1:0];
        dv_dvd_q[k+1]  <= {dv_dvd_q[k][DivW-2:0], take};
        dv_dsr_q[k+1]  <= dv_dsr_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_err_q[k+1]  <= dv_err_q[k];
        dv_temp_q[k+1] <= dv_temp_q[k];
      end
    end
  end

  // Pressure refinement.
  logic [63:0]             s9_q_q;
  logic                    s9_err_q;
  logic signed [TempW-1:0] s9_temp_q;

  logic [63:0] s9_d;
  logic [63:0] s9_ll;
  logic [63:0] s9_x;
  assign s9_d  = {{13{s9_q_q[63]}}, s9_q_q[63:13]};
  assign s9_ll = 64'(s9_d[31:0]) * 64'(s9_d[31:0]);
  assign s9_x  = 64'(s9_d[31:0]) * 64'(s9_d[63:32]);

  logic [63:0]             s10_ll_q, s10_m8_q, s10_q_q;
  logic [31:0]             s10_x_q;
  logic                    s10_err_q;
  logic signed [TempW-1:0] s10_temp_q;

  logic [63:0]             s11_dd_q, s11_m8_q, s11_q_q;
  logic                    s11_err_q;
  logic signed [TempW-1:0] s11_temp_q;

  logic [63:0]             s12_m9_q, s12_m8_q, s12_q_q;
  logic                    s12_err_q;
  logic signed [TempW-1:0] s12_temp_q;

  logic [63:0] s12_sum;
  assign s12_sum = s12_q_q + {{25{s12_m9_q[63]}}, s12_m9_q[63:25]}
                 + {{19{s12_m8_q[63]}}, s12_m8_q[63:19]};

  logic [63:0]             s13_res_q;
  logic                    s13_err_q;
  logic signed [TempW-1:0] s13_temp_q;

  logic [PressW-1:0] s13_press;
  always_comb begin
    if (s13_err_q || s13_res_q[63]) begin
      s13_press = '0;
    end else if (|s13_res_q[62:PressW]) begin
      s13_press = PressMax;
    end else begin
      s13_press = s13_res_q[PressW-1:0];
    end
  end

  logic signed [TempW-1:0] out_temp_q;
  logic [PressW-1:0]       out_press_q;
  logic                    out_err_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_q_q     <= dv_neg_q[DivW] ? 64'(-dv_dvd_q[DivW]) : dv_dvd_q[DivW];
      s9_err_q   <= dv_err_q[DivW];
      s9_temp_q  <= dv_temp_q[DivW];

      s10_ll_q   <= s9_ll;
      s10_x_q    <= s9_x[31:0];
      s10_m8_q   <= mul_s16(s9_q_q, p8);
      s10_q_q    <= s9_q_q;
      s10_err_q  <= s9_err_q;
      s10_temp_q <= s9_temp_q;

      s11_dd_q   <= s10_ll_q + {s10_x_q[30:0], 1'b0, 32'h0000_0000};
      s11_m8_q   <= s10_m8_q;
      s11_q_q    <= s10_q_q;
      s11_err_q  <= s10_err_q;
      s11_temp_q <= s10_temp_q;

      s12_m9_q   <= mul_s16(s11_dd_q, p9);
      s12_m8_q   <= s11_m8_q;
      s12_q_q    <= s11_q_q;
      s12_err_q  <= s11_err_q;
      s12_temp_q <= s11_temp_q;

      s13_res_q  <= {{8{s12_sum[63]}}, s12_sum[63:8]} + (64'(p7) << 4);
      s13_err_q  <= s12_err_q;
      s13_temp_q <= s12_temp_q;

      out_temp_q  <= s13_temp_q;
      out_press_q <= s13_press;
      out_err_q   <= s13_err_q;
    end
  end

  assign out_if.temperature_centi = out_temp_q;
  assign out_if.pressure_q24_8    = out_press_q;
  assign out_if.divide_error      = out_err_q;

endmodule

/* sv/ptc_checker.sv */
// ----------------------------------------------------------------------------
// Compensation port checker
// Watches the channels of the top level and flags illegal results and handshakes.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [ptc_pkg::TempW-1:0]    temperature_centi_i,
  input logic [ptc_pkg::PressW-1:0]          pressure_q24_8_i,
  input logic                                divide_error_i
);
  import ptc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(temperature_centi_i) && $stable(pressure_q24_8_i)
      && $stable(divide_error_i))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && divide_error_i |-> pressure_q24_8_i == '0)
    else $error("pressure not zero on divide error");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> temperature_centi_i >= TempMin && temperature_centi_i <= TempMax)
    else $error("temperature out of range");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while the pipeline is stalled");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_i          (in_if.ready),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .temperature_centi_i (out_if.temperature_centi),
  .pressure_q24_8_i    (out_if.pressure_q24_8),
  .divide_error_i      (out_if.divide_error)
);

/* verif/pressure_temperature_compensation_test.sv */
// ----------------------------------------------------------------------------
// Pressure and temperature compensation testbench
// Drives raw reading beats through the compensation pipeline under several
// calibration settings, predicts each result in 64-bit wrapping arithmetic
// and compares every output beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pressure_temperature_compensation_test;
  import ptc_pkg::*;

  typedef struct packed {
    logic [AdcW-1:0] adc_t;
    logic [AdcW-1:0] adc_p;
  } reading_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PressW-1:0]       press;
    logic                    div_err;
  } comp_t;

  typedef struct {
    reading_t rd;
    logic     typed;
    comp_t    res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CalW-1:0] cfg_data_i;

  ptc_in_if  in_if ();
  ptc_out_if out_if ();

  pressure_temperature_compensation uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if.sink),
    .out_if      (out_if.source)
  );

  logic [CalW-1:0] cal [4];
  comp_t expected_q [$];
  int errors;
  int send_idle;
  int recv_idle;
  bit hold_off;
  longint unsigned cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] sar(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sx(input logic [WordW-1:0] w);
    return {{48{w[WordW-1]}}, w};
  endfunction

  function automatic comp_t compensate(input reading_t rd);
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, d, t_fine, t, p, mag, ma, mb, q;
    comp_t r;
    t1 = 64'(cal[REG_TEMP_CAL][15:0]);
    t2 = sx(cal[REG_TEMP_CAL][31:16]);
    t3 = sx(cal[REG_TEMP_CAL][47:32]);
    p1 = 64'(cal[REG_PRESS_CAL_A][15:0]);
    p2 = sx(cal[REG_PRESS_CAL_A][31:16]);
    p3 = sx(cal[REG_PRESS_CAL_A][47:32]);
    p4 = sx(cal[REG_PRESS_CAL_B][15:0]);
    p5 = sx(cal[REG_PRESS_CAL_B][31:16]);
    p6 = sx(cal[REG_PRESS_CAL_B][47:32]);
    p7 = sx(cal[REG_PRESS_CAL_C][15:0]);
    p8 = sx(cal[REG_PRESS_CAL_C][31:16]);
    p9 = sx(cal[REG_PRESS_CAL_C][47:32]);
    r.div_err = 1'b0;
    r.press = '0;
    a = sar(((64'(rd.adc_t) >> 3) - (t1 << 1)) * t2, 11);
    d = (64'(rd.adc_t) >> 4) - t1;
    b = sar(sar(d * d, 12) * t3, 14);
    t_fine = a + b;
    t = sar(t_fine * 5 + 128, 8);
    if (t[63]) begin
      mag = -t;
      if (mag > 4000) mag = 4000;
      t = -mag;
    end else if (t > 8500) begin
      t = 8500;
    end
    r.temp = t[TempW-1:0];
    a = t_fine - 128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = sar(a * a * p3, 8) + ((a * p2) << 12);
    a = sar(((64'd1 << 47) + a) * p1, 33);
    if (a == 0) begin
      r.div_err = 1'b1;
    end else begin
      p = 64'd1048576 - 64'(rd.adc_p);
      p = ((p << 31) - b) * 3125;
      ma = p[63] ? -p : p;
      mb = a[63] ? -a : a;
      q = ma / mb;
      p = (p[63] != a[63]) ? -q : q;
      d = sar(p, 13);
      a = sar(p9 * d * d, 25);
      b = sar(p8 * p, 19);
      p = sar(p + a + b, 8) + (p7 << 4);
      if (p[63]) r.press = '0;
      else if (p > 64'(PressMax)) r.press = PressMax;
      else r.press = p[PressW-1:0];
    end
    return r;
  endfunction

  task automatic write_bank(input logic [CalW-1:0] vals [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      cal[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send(input reading_t rd, input logic typed, input comp_t res);
    comp_t pred;
    pred = compensate(rd);
    if (typed && pred != res) begin
      $error("typed row differs from prediction: exp %h got %h", res, pred);
      errors++;
    end
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.adc_temperature <= rd.adc_t;
    in_if.adc_pressure <= rd.adc_p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(pred);
  endtask

  function automatic reading_t rand_reading();
    reading_t rd;
    rd.adc_t = $urandom_range(9) == 0 ? AdcW'($urandom) : AdcW'($urandom_range(600000, 350000));
    rd.adc_p = $urandom_range(9) == 0 ? AdcW'($urandom) : AdcW'($urandom_range(450000, 250000));
    return rd;
  endfunction

  function automatic logic [CalW-1:0] rand_cal(input cfg_reg_e idx);
    logic [CalW-1:0] v;
    v = {16'($urandom), 16'($urandom), 16'($urandom)};
    if ($urandom_range(3) != 0) begin
      case (idx)
        REG_TEMP_CAL: begin
          v = {16'(-7 + $urandom_range(14)), 16'(26000 + $urandom_range(2000)),
               16'(27000 + $urandom_range(2000))};
        end
        REG_PRESS_CAL_A: begin
          v = {16'(3000 + $urandom_range(3000)), 16'(-12000 + $urandom_range(2000)),
               16'(35000 + $urandom_range(5000))};
        end
        REG_PRESS_CAL_B: begin
          v = {16'(-10 + $urandom_range(20)), 16'(-200 + $urandom_range(400)),
               16'(2000 + $urandom_range(6000))};
        end
        default: begin
          v = {16'(5000 + $urandom_range(3000)), 16'(-15000 + $urandom_range(5000)),
               16'($urandom_range(50))};
        end
      endcase
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    comp_t got, exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.temperature_centi, out_if.pressure_q24_8, out_if.divide_error};
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.temp !== exp_r.temp) begin
          $error("temperature_centi exp %0d got %0d", exp_r.temp, got.temp);
          errors++;
        end
        if (got.press !== exp_r.press) begin
          $error("pressure_q24_8 exp %0d got %0d", exp_r.press, got.press);
          errors++;
        end
        if (got.div_err !== exp_r.div_err) begin
          $error("divide_error exp %0d got %0d", exp_r.div_err, got.div_err);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("FAIL pressure_temperature_compensation");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    comp_t c0;
    logic [CalW-1:0] nominal [4];
    logic [CalW-1:0] bank [4];
    int phase;
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 4; i++) cal[i] = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_TEMP_CAL;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.adc_temperature = '0;
    in_if.adc_pressure = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All calibration zero: temperature 0 and a zero divisor.
    c0 = '{temp: '0, press: '0, div_err: 1'b1};
    rows.push_back('{'{'0, '0}, 1'b1, c0});
    rows.push_back('{'{'1, '1}, 1'b1, c0});
    rows.push_back('{'{20'h55555, 20'haaaaa}, 1'b1, c0});
    foreach (rows[i]) send(rows[i].rd, rows[i].typed, rows[i].res);
    drain();
    rows.delete();

    nominal[0] = {16'd50, 16'd26435, 16'd27504};
    nominal[1] = {16'd3024, -16'sd10685, 16'd36477};
    nominal[2] = {-16'sd7, 16'd140, 16'd2855};
    nominal[3] = {16'd4000, -16'sd14600, 16'd15500};
    write_bank(nominal);
    rows.push_back('{'{20'd519888, 20'd415148}, 1'b0, c0});
    rows.push_back('{'{'0, '0}, 1'b0, c0});
    rows.push_back('{'{'1, '1}, 1'b0, c0});
    rows.push_back('{'{'0, '1}, 1'b0, c0});
    rows.push_back('{'{'1, '0}, 1'b0, c0});
    rows.push_back('{'{20'h55555, 20'haaaaa}, 1'b0, c0});
    rows.push_back('{'{20'haaaaa, 20'h55555}, 1'b0, c0});
    foreach (rows[i]) send(rows[i].rd, rows[i].typed, rows[i].res);
    drain();
    rows.delete();

    // Extreme calibration: all ones, then sign extremes.
    for (int i = 0; i < 4; i++) bank[i] = '1;
    write_bank(bank);
    for (int i = 0; i < 4; i++) send(rand_reading(), 1'b0, c0);
    send('{'0, '0}, 1'b0, c0);
    send('{'1, '1}, 1'b0, c0);
    drain();
    for (int i = 0; i < 4; i++) bank[i] = {3{16'h8000}};
    write_bank(bank);
    for (int i = 0; i < 4; i++) send(rand_reading(), 1'b0, c0);
    send('{'1, '0}, 1'b0, c0);
    drain();
    for (int i = 0; i < 4; i++) bank[i] = {3{16'h7fff}};
    write_bank(bank);
    for (int i = 0; i < 4; i++) send(rand_reading(), 1'b0, c0);
    send('{'0, '1}, 1'b0, c0);
    drain();

    for (phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        send_idle = 8;
        recv_idle = 73;
      end else if (phase < 6) begin
        send_idle = 73;
        recv_idle = 8;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < 4; i++) begin
        bank[i] = phase == 8 ? nominal[i] : rand_cal(cfg_reg_e'(i));
      end
      write_bank(bank);
      if (phase == 6) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; n++) send(rand_reading(), 1'b0, c0);
      drain();
    end

    if (errors == 0) begin
      $display("PASS pressure_temperature_compensation");
    end else begin
      $display("FAIL pressure_temperature_compensation");
    end
    $finish;
  end

endmodule

/* pressure_temperature_compensation.f */
sv/ptc_pkg.sv
sv/ptc_in_if.sv
sv/ptc_out_if.sv
sv/pressure_temperature_compensation.sv
sv/ptc_checker.sv
verif/pressure_temperature_compensation_test.sv
